@@ sv/assert_macros.svh @@
// Assertion helpers for the calibrator core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check a property including during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

@@ sv/wmsc_pkg.sv @@
// ----------------------------------------------------------------------------
// wmsc_pkg
// Shared widths and codes for the sliding-window median calibrator.
// ----------------------------------------------------------------------------
package wmsc_pkg;
  localparam int Depth   = 32;
  localparam int IdxW    = $clog2(Depth);
  localparam int CntW    = $clog2(Depth + 1);
  localparam int DataW   = 32;
  localparam int CfgW    = 6;
  localparam int InW     = 40;
  localparam int OutW    = 40;
  localparam logic [CfgW-1:0] MinRatiosReset = CfgW'(16);
  localparam logic CmdPush  = 1'b0;
  localparam logic CmdClear = 1'b1;
endpackage

@@ sv/window_median_scale_calibrator_core.sv @@
// ----------------------------------------------------------------------------
// window_median_scale_calibrator_core
// Sliding window of 32 Q16.16 ratios, median select and consistency check.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command word: tuser = command (0 push, 1 clear),
//   tdata = ratio. m_axis returns one word per command: scale, ready_res, fill.
//   cfg_valid/cfg_ready write min_ratios; write only while idle.
// Timing:
//   A clear has its result valid the cycle after accept. A push that does not
//   reach min_ratios passes through S_WRITE to the output. A push that
//   computes the median runs a single shared comparator over the window: up
//   to fill candidates for the rank search, then one pass for the consistency
//   count before the result is registered.
//   The history memory port (one read per cycle) paces these passes.
//   Input is not accepted while an item is in work or its result waits.
// Reset:
//   rst clears fill, scale, ready flag and min_ratios (to 16). The history
//   memory is not cleared.
// Stall:
//   The result holds in the output register until m_axis_tready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module window_median_scale_calibrator_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [wmsc_pkg::DataW-1:0]  s_axis_tdata,   // [31:0] ratio
  input  logic                        s_axis_tuser,   // [0] command
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [wmsc_pkg::OutW-1:0]   m_axis_tdata,   // [31:0] scale, [32] ready_res,
                                                      // [38:33] fill, [39] zero
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [wmsc_pkg::CfgW-1:0]   cfg_data
);
  import wmsc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_WRITE, S_RANK, S_CHECK, S_CONS, S_DONE, S_OUT
  } state_t;

  state_t                  state;
  logic [DataW-1:0]        mem [Depth];
  logic [DataW-1:0]        rd_data;
  logic [IdxW-1:0]         rd_addr;
  logic [CntW-1:0]         held;
  logic [IdxW-1:0]         oldest;
  logic [DataW-1:0]        scale;
  logic                    ready_flag;
  logic [CfgW-1:0]         min_ratios;
  logic [DataW-1:0]        ratio;
  logic [DataW-1:0]        cand;
  logic                    cand_ok;
  logic [DataW-1:0]        median;
  logic [CntW-1:0]         oi;
  logic [CntW-1:0]         ij;
  logic                    rd_pend;
  logic [CntW-1:0]         less;
  logic [CntW-1:0]         leq;
  logic [CntW-1:0]         cons;
  logic [CntW-1:0]         k;
  logic                    lt;
  logic                    eq;
  logic [DataW:0]          abs_m;
  logic signed [DataW+1:0] diff;
  logic [DataW+1:0]        abs_d;
  logic [DataW+3:0]        d4;
  logic [CntW+2:0]         cons4;
  logic [CntW+2:0]         held3;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = {1'b0, 6'(held), ready_flag, scale};
  assign k             = held >> 1;

  // shared comparator and magnitude unit
  assign lt    = $signed(rd_data) < $signed(cand);
  assign eq    = rd_data == cand;
  assign abs_m = median[DataW-1] ? (DataW+1)'(-$signed({median[DataW-1], median}))
                                 : {1'b0, median};
  assign diff  = $signed({{2{rd_data[DataW-1]}}, rd_data})
               - $signed({{2{median[DataW-1]}}, median});
  assign abs_d = diff[DataW+1] ? (DataW+2)'(-diff) : (DataW+2)'(diff);
  assign d4    = {abs_d, 2'b00};
  assign cons4 = {1'b0, cons, 2'b00};
  assign held3 = (CntW+3)'(held) + (CntW+3)'({held, 1'b0});

  always_ff @(posedge clk) begin
    if (state == S_WRITE) begin
      mem[held < CntW'(Depth) ? IdxW'(oldest + IdxW'(held)) : oldest] <= ratio;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      held       <= '0;
      oldest     <= '0;
      scale      <= '0;
      ready_flag <= 1'b0;
      min_ratios <= MinRatiosReset;
      rd_pend    <= 1'b0;
      cand_ok    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            min_ratios <= cfg_data;
          end
          if (s_axis_tvalid) begin
            ratio <= s_axis_tdata;
            if (s_axis_tuser == CmdClear) begin
              held       <= '0;
              oldest     <= '0;
              scale      <= '0;
              ready_flag <= 1'b0;
              state      <= S_OUT;
            end else begin
              ready_flag <= 1'b0;
              state      <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          if (held < CntW'(Depth)) begin
            held <= held + 1'b1;
            if (held + 1'b1 >= CntW'(min_ratios)) state <= S_RANK;
            else state <= S_OUT;
          end else begin
            oldest <= oldest + 1'b1;
            if (held >= CntW'(min_ratios)) state <= S_RANK;
            else state <= S_OUT;
          end
          oi      <= '0;
          ij      <= '0;
          rd_addr <= '0;
          rd_pend <= 1'b0;
          cand_ok <= 1'b0;
          less    <= '0;
          leq     <= '0;
        end
        S_RANK: begin
          // fetch candidate, then stream the window against it
          if (!rd_pend) begin
            rd_pend <= 1'b1;
            rd_addr <= '0;
            ij      <= '0;
          end else if (!cand_ok) begin
            cand    <= rd_data;
            cand_ok <= 1'b1;
            rd_addr <= IdxW'(1);
            ij      <= CntW'(1);
          end else begin
            if (lt) less <= less + 1'b1;
            if (lt || eq) leq <= leq + 1'b1;
            if (ij == held) begin
              state <= S_CHECK;
            end else begin
              rd_addr <= IdxW'(ij + 1'b1);
              ij      <= ij + 1'b1;
            end
          end
        end
        S_CHECK: begin
          if (less <= k && k < leq) begin
            median  <= cand;
            cons    <= '0;
            ij      <= '0;
            rd_addr <= '0;
            state   <= (cand == '0) ? S_OUT : S_CONS;
          end else begin
            oi      <= oi + 1'b1;
            rd_addr <= IdxW'(oi + 1'b1);
            rd_pend <= 1'b0;
            cand_ok <= 1'b0;
            less    <= '0;
            leq     <= '0;
            state   <= (oi + 1'b1 == held) ? S_OUT : S_RANK;
          end
        end
        S_CONS: begin
          if (ij != '0 && d4 <= (DataW+4)'(abs_m)) cons <= cons + 1'b1;
          if (ij == held) state <= S_DONE;
          else begin
            rd_addr <= IdxW'(ij + 1'b1);
            ij      <= ij + 1'b1;
          end
        end
        S_DONE: begin
          if (cons4 >= held3) begin
            scale      <= median;
            ready_flag <= 1'b1;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (m_axis_tready) state <= S_IDLE;
          cand_ok <= 1'b0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_fill_range, held <= CntW'(Depth), "fill above window depth")
  `ASSERT_CLK(a_ready_scale, ready_flag |-> scale != '0, "ready with zero scale")
  `ASSERT_CLK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "stall")
  `ASSERT_CLK(a_no_accept_busy, state != S_IDLE |-> !s_axis_tready, "accept while busy")
endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sliding-window median calibrator: pushes and
// clears stream in under random stalls, a local model predicts scale, ready
// and fill for each command, and every output word is compared in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wmsc_pkg::*;

  typedef struct packed {
    logic             command;
    logic [DataW-1:0] ratio;
  } cmd_word_t;

  typedef struct packed {
    logic [DataW-1:0] scale;
    logic             ready_res;
    logic [CfgW-1:0]  fill;
  } cal_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [DataW-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutW-1:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgW-1:0] cfg_data = '0;

  window_median_scale_calibrator_core uut (.*);

  cmd_word_t pending_cmds[$];
  cal_word_t expected_cal[$];
  int        errors = 0;
  int        send_idle_pct = 7;
  int        recv_idle_pct = 77;
  longint    cycles = 0;

  logic signed [DataW-1:0] win[Depth];
  int                      win_held = 0;
  int                      win_oldest = 0;
  logic [DataW-1:0]        cal_scale = '0;
  logic                    cal_ready = 1'b0;
  int                      min_fill = 16;

  initial forever #6 clk = ~clk;

  function automatic void add_cmd(cmd_word_t c);
    pending_cmds = {pending_cmds, c};
  endfunction

  function automatic cmd_word_t take_cmd();
    cmd_word_t c;
    c = pending_cmds[0];
    pending_cmds.delete(0);
    return c;
  endfunction

  function automatic longint abs_l(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic cal_word_t predict_cal(cmd_word_t c);
    cal_word_t r;
    longint m, lim;
    int k, less, leq, hits;
    bit found;
    if (c.command == CmdClear) begin
      win_held = 0;
      win_oldest = 0;
      cal_scale = '0;
      cal_ready = 1'b0;
    end else begin
      if (win_held < Depth) begin
        win[(win_oldest + win_held) % Depth] = c.ratio;
        win_held++;
      end else begin
        win[win_oldest] = c.ratio;
        win_oldest = (win_oldest + 1) % Depth;
      end
      cal_ready = 1'b0;
      if (win_held >= min_fill) begin
        k = win_held / 2;
        m = 0;
        found = 0;
        for (int i = 0; i < win_held && !found; i++) begin
          less = 0;
          leq = 0;
          for (int j = 0; j < win_held; j++) begin
            if (win[j] < win[i]) less++;
            if (win[j] <= win[i]) leq++;
          end
          if (less <= k && k < leq) begin
            m = win[i];
            found = 1;
          end
        end
        if (m != 0) begin
          lim = abs_l(m);
          hits = 0;
          for (int i = 0; i < win_held; i++)
            if (4 * abs_l(longint'(win[i]) - m) <= lim) hits++;
          if (4 * hits >= 3 * win_held) begin
            cal_scale = m[DataW-1:0];
            cal_ready = 1'b1;
          end
        end
      end
    end
    r.scale = cal_scale;
    r.ready_res = cal_ready;
    r.fill = CfgW'(win_held);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        expected_cal = {expected_cal, predict_cal({s_axis_tuser, s_axis_tdata})};
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd_word_t c;
          c = take_cmd();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= c.command;
          s_axis_tdata <= c.ratio;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      cal_word_t got, want;
      got.scale = m_axis_tdata[31:0];
      got.ready_res = m_axis_tdata[32];
      got.fill = m_axis_tdata[38:33];
      if (expected_cal.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata, 0);
      end else begin
        want = expected_cal[0];
        expected_cal.delete(0);
        if (got.scale !== want.scale) report_mismatch("scale", got.scale, want.scale);
        if (got.ready_res !== want.ready_res)
          report_mismatch("ready_res", got.ready_res, want.ready_res);
        if (got.fill !== want.fill) report_mismatch("fill", got.fill, want.fill);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 10000000) begin
      $display("[window_median_scale_calibrator_core] ERROR");
      $finish;
    end
  end

  function automatic cmd_word_t mk(logic cmd, logic [DataW-1:0] v);
    cmd_word_t c;
    c.command = cmd;
    c.ratio = v;
    return c;
  endfunction

  task automatic drain();
    wait (pending_cmds.size() == 0);
    @(posedge clk);
    while (s_axis_tvalid || expected_cal.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_min_fill(int v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= CfgW'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    min_fill = v;
  endtask

  // a run of values scattered around a center, with a few outliers
  task automatic queue_cluster(int n, int spread_pct);
    int center, d;
    center = $urandom_range(1, 1 << 20);
    if ($urandom_range(1)) center = -center;
    for (int i = 0; i < n; i++) begin
      d = (center / 100) * $urandom_range(spread_pct);
      if ($urandom_range(1)) d = -d;
      if ($urandom_range(9) == 0) add_cmd(mk(CmdPush, $urandom));
      else add_cmd(mk(CmdPush, center + d));
    end
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) begin
      int r;
      r = $urandom_range(99);
      if (r < 3) add_cmd(mk(CmdClear, $urandom));
      else if (r < 75) queue_cluster($urandom_range(1, 12), $urandom_range(40));
      else if (r < 85) add_cmd(mk(CmdPush, '0));
      else add_cmd(mk(CmdPush, $urandom));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, zero median, clears, full window wrap
    add_cmd(mk(CmdPush, 32'h8000_0000));
    add_cmd(mk(CmdPush, 32'h7fff_ffff));
    add_cmd(mk(CmdClear, 32'hffff_ffff));
    for (int i = 0; i < 16; i++) add_cmd(mk(CmdPush, 32'h0001_0000 + i));
    add_cmd(mk(CmdPush, 32'h0000_0000));
    add_cmd(mk(CmdClear, 32'h0));
    drain();
    write_min_fill(0);
    add_cmd(mk(CmdPush, 32'h0));
    add_cmd(mk(CmdPush, 32'hffff_0000));
    add_cmd(mk(CmdPush, 32'h7fff_ffff));
    drain();
    write_min_fill(63);
    queue_cluster(40, 5);
    drain();
    write_min_fill(32);
    queue_cluster(40, 5);
    add_cmd(mk(CmdClear, 32'h0));
    drain();

    send_idle_pct = 7;
    recv_idle_pct = 77;
    write_min_fill(1);
    queue_random(60);
    drain();
    write_min_fill(8);
    queue_random(60);
    // hold off until every result is back
    drain();
    send_idle_pct = 77;
    recv_idle_pct = 7;
    queue_random(60);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_min_fill(16);
    queue_random(60);
    drain();
    write_min_fill(32);
    queue_random(30);
    drain();

    if (errors == 0) begin
      $display("[window_median_scale_calibrator_core] OK");
    end else begin
      $display("[window_median_scale_calibrator_core] ERROR");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+sv
sv/wmsc_pkg.sv
sv/window_median_scale_calibrator_core.sv
bench/tb_top.sv
